// ===== sv/gmas_pkg.sv =====
// Shared types and constants for the gated moving-average scaler.
// No dependencies; imported by every module of the block.
package gmas_pkg;

	localparam int RAW_W       = 16;
	localparam int CODE_W      = 12;
	localparam int CODE_LSB    = 4;
	localparam int CODE_MAX    = (1 << CODE_W) - 1;
	localparam int HIGH_W      = 13;
	localparam int GAIN_W      = 24;
	localparam int OFFSET_W    = 32;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int READING_W   = 40;
	localparam int COUNT_OUT_W = 5;
	localparam int DEPTH_DEF   = 16;

	localparam logic [CODE_W-1:0]          LOW_CODE_RST  = 12'd1024;
	localparam logic [HIGH_W-1:0]          HIGH_CODE_RST = 13'd4096;
	localparam logic [GAIN_W-1:0]          GAIN_RST      = 24'd81920;
	localparam logic signed [OFFSET_W-1:0] OFFSET_RST    = 32'sd3355443;

	localparam logic signed [READING_W-1:0] READING_MAX = {1'b0, {(READING_W-1){1'b1}}};
	localparam logic signed [READING_W-1:0] READING_MIN = {1'b1, {(READING_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_CODE  = 2'd0,
		REG_HIGH_CODE = 2'd1,
		REG_GAIN      = 2'd2,
		REG_OFFSET    = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WRITE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	// ring memory commands from the sequencer
	typedef struct packed {
		logic rd;
		logic wr;
	} ring_ctrl_t;

endpackage

// ===== sv/gated_moving_average_scaler.sv =====
// Gated moving-average scaler: range gate, sample ring, scaled mean.
// Top level; depends on gmas_pkg, gmas_ring and gmas_div.
//
// Usage notes:
//  - Input channel (in_valid/in_ready, raw_word): code = raw_word[15:4]. The
//    code enters the ring only if low_code < code < high_code.
//  - Output channel (out_valid/out_ready): one item per input item, giving
//    reading = floor(sum*gain/count) + offset (signed Q.24, clamped to 40 bits),
//    accepted, and valid_count (the count of filled ring slots, low 5 bits).
//  - Config port (cfg_we/cfg_index/cfg_data): single-cycle writes, no read-back.
//    Write only while no item is in flight.
//  - One item is worked at a time. PROD_W = SUM_W + 24 is the product width;
//    the serial divider works through it, one quotient bit per cycle. A rejected
//    code skips the ring read/write. No new item is taken until the last result
//    is loaded into the output register.
//  - The result sits in an output register; a stalled receiver holds it there
//    and the next item is accepted and worked meanwhile, waiting only at the end.
//  - Reset clears the ring (valid bits, running sum and count), the write slot
//    and restores the register defaults. No clearing pass is needed.
module gated_moving_average_scaler #(
	parameter int DEPTH = gmas_pkg::DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [gmas_pkg::RAW_W-1:0]            raw_word,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [gmas_pkg::READING_W-1:0] reading,
	output logic                                  accepted,
	output logic [gmas_pkg::COUNT_OUT_W-1:0]      valid_count,
	// config write port
	input  logic                                  cfg_we,
	input  logic [gmas_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [gmas_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import gmas_pkg::*;

	localparam int SUM_W  = $clog2(DEPTH * CODE_MAX + 1);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int PROD_W = SUM_W + GAIN_W;
	localparam int R_W    = ((PROD_W > READING_W) ? PROD_W : READING_W) + 2;

	// config registers
	logic [CODE_W-1:0]          low_code_q;
	logic [HIGH_W-1:0]          high_code_q;
	logic [GAIN_W-1:0]          gain_q;
	logic signed [OFFSET_W-1:0] offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_code_q  <= LOW_CODE_RST;
			high_code_q <= HIGH_CODE_RST;
			gain_q      <= GAIN_RST;
			offset_q    <= OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_LOW_CODE:  low_code_q  <= cfg_data[CODE_W-1:0];
				REG_HIGH_CODE: high_code_q <= cfg_data[HIGH_W-1:0];
				REG_GAIN:      gain_q      <= cfg_data[GAIN_W-1:0];
				REG_OFFSET:    offset_q    <= $signed(cfg_data[OFFSET_W-1:0]);
				default:       ;
			endcase
		end
	end

	// range gate on the incoming code
	logic [CODE_W-1:0] in_code;
	logic              in_acc;
	logic              in_fire;

	assign in_code = raw_word[CODE_LSB +: CODE_W];
	assign in_acc  = (in_code > low_code_q) && ({1'b0, in_code} < high_code_q);
	assign in_fire = in_valid && in_ready;

	logic [CODE_W-1:0] code_q;
	logic              acc_q;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			code_q <= in_code;
			acc_q  <= in_acc;
		end
	end

	// sequencer
	state_t     state_q, state_nxt;
	ring_ctrl_t ring_ctrl;
	logic       div_start;
	logic       div_done;
	logic       out_load;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_nxt = in_acc ? ST_READ : ST_MUL;
			ST_READ:  state_nxt = ST_WRITE;
			ST_WRITE: state_nxt = ST_MUL;
			ST_MUL:   state_nxt = ST_DIV;
			ST_DIV:   if (div_done) state_nxt = ST_FIN;
			ST_FIN:   if (!out_valid_q || out_ready) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		ring_ctrl.rd = 1'b0;
		ring_ctrl.wr = 1'b0;
		div_start    = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE:  in_ready     = 1'b1;
			ST_READ:  ring_ctrl.rd = 1'b1;
			ST_WRITE: ring_ctrl.wr = 1'b1;
			ST_MUL:   div_start    = 1'b1;
			ST_DIV:   ;
			ST_FIN:   out_load     = !out_valid_q || out_ready;
			default:  ;
		endcase
	end

	// ring with running sum and count
	logic [SUM_W-1:0] ring_sum;
	logic [CNT_W-1:0] ring_count;

	gmas_ring #(
		.DEPTH (DEPTH),
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ring_ctrl),
		.code   (code_q),
		.sum    (ring_sum),
		.count  (ring_count)
	);

	// sum*gain feeds the divider's dividend register directly
	logic [PROD_W-1:0] product;
	logic [CNT_W-1:0]  divisor;
	logic [PROD_W-1:0] quotient;

	assign product = {{GAIN_W{1'b0}}, ring_sum} * {{SUM_W{1'b0}}, gain_q};
	assign divisor = (ring_count == '0) ? CNT_W'(1) : ring_count;

	gmas_div #(
		.N (PROD_W),
		.D (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (divisor),
		.quotient (quotient),
		.done     (div_done)
	);

	// offset and clamp
	logic signed [R_W-1:0]       r_sum;
	logic signed [R_W-1:0]       r_max;
	logic signed [R_W-1:0]       r_min;
	logic signed [READING_W-1:0] r_sat;

	assign r_max = R_W'(READING_MAX);
	assign r_min = R_W'(READING_MIN);
	assign r_sum = R_W'($signed({1'b0, quotient})) + R_W'(offset_q);

	always_comb begin
		if (r_sum > r_max) begin
			r_sat = READING_MAX;
		end else if (r_sum < r_min) begin
			r_sat = READING_MIN;
		end else begin
			r_sat = r_sum[READING_W-1:0];
		end
	end

	// output register
	logic signed [READING_W-1:0] reading_q;
	logic                        accepted_q;
	logic [COUNT_OUT_W-1:0]      valid_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			reading_q     <= r_sat;
			accepted_q    <= acc_q;
			valid_count_q <= COUNT_OUT_W'(ring_count);
		end
	end

	assign out_valid   = out_valid_q;
	assign reading     = reading_q;
	assign accepted    = accepted_q;
	assign valid_count = valid_count_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ring_count <= CNT_W'(DEPTH))
		else $error("ring count above depth");

	a_wr_only_acc: assert property (@(posedge clk) disable iff (!arst_n)
		ring_ctrl.wr |-> acc_q)
		else $error("ring written for a rejected code");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside its wait state");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("second item taken while one is in flight");

endmodule

// ===== sv/gmas_ring.sv =====
// Sample ring: one-port code memory with per-slot valid bits, write pointer
// and running sum/count kept by read-modify-write. Depends on gmas_pkg.
module gmas_ring #(
	parameter int DEPTH = gmas_pkg::DEPTH_DEF,
	parameter int SUM_W = $clog2(DEPTH * gmas_pkg::CODE_MAX + 1),
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gmas_pkg::ring_ctrl_t        ctrl,
	input  logic [gmas_pkg::CODE_W-1:0] code,
	output logic [SUM_W-1:0]            sum,
	output logic [CNT_W-1:0]            count
);
	import gmas_pkg::*;

	localparam int SLOT_W = $clog2(DEPTH);

	logic [CODE_W-1:0] mem [DEPTH];
	logic [CODE_W-1:0] rd_data_s1;
	logic [DEPTH-1:0]  valid_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  count_q;
	logic [CODE_W-1:0] old_code;

	always_ff @(posedge clk) begin
		if (ctrl.rd) begin
			rd_data_s1 <= mem[slot_q];
		end
		if (ctrl.wr) begin
			mem[slot_q] <= code;
		end
	end

	// a never-written slot reads as zero
	assign old_code = valid_q[slot_q] ? rd_data_s1 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			slot_q  <= '0;
			sum_q   <= '0;
			count_q <= '0;
		end else if (ctrl.wr) begin
			valid_q[slot_q] <= 1'b1;
			sum_q <= sum_q - SUM_W'(old_code) + SUM_W'(code);
			if (!valid_q[slot_q]) begin
				count_q <= count_q + 1'b1;
			end
			slot_q <= (slot_q == SLOT_W'(DEPTH - 1)) ? '0 : slot_q + 1'b1;
		end
	end

	assign sum   = sum_q;
	assign count = count_q;

endmodule

// ===== sv/gmas_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Depends on gmas_pkg (style only); used by the top level for the mean.
module gmas_div #(
	parameter int N = 40,
	parameter int D = 5
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [D-1:0] divisor,
	output logic [N-1:0] quotient,
	output logic         done
);
	import gmas_pkg::*;

	localparam int CW = $clog2(N + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [D-1:0]  rem_q;
	logic [D-1:0]  div_q;
	logic [N-1:0]  quo_q;
	logic [D:0]    rem_sh;
	logic [D+1:0]  diff;

	assign rem_sh = {rem_q, quo_q[N-1]};
	assign diff   = {1'b0, rem_sh} - {2'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!diff[D+1]) begin
				rem_q <= diff[D-1:0];
				quo_q <= {quo_q[N-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[D-1:0];
				quo_q <= {quo_q[N-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== tb/sv/gated_moving_average_scaler_tb.sv =====
// Testbench for gated_moving_average_scaler: directed and random raw words
// over several register settings, with results checked in order against a predictor.
// Depends on gmas_pkg and the gated_moving_average_scaler RTL.
module gated_moving_average_scaler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gmas_pkg::*;

	localparam int CLK_PERIOD = 20;
	localparam int RST_CYCLES = 7;
	// the limit is several times the slowest legal run (every item meeting
	// the longest gap and stall)
	localparam longint RUN_LIMIT_NS = 64'd25_000_000;
	localparam int RAND_PHASES = 10;
	localparam int PHASE_ITEMS = 135;
	localparam int MAX_REPORTS = 10;
	localparam int TAIL_CYCLES = 100;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic signed [READING_W-1:0] reading;
		logic                        accepted;
		logic [COUNT_OUT_W-1:0]      count;
	} reading_t;

	// Mirrors the ring, the write slot and the four registers; predicts one
	// reading per raw word and checks the block's readings in order.
	class reading_scoreboard;
		logic [CODE_W-1:0]          ring[DEPTH_DEF];
		int unsigned                slot;
		logic [CODE_W-1:0]          low_code;
		logic [HIGH_W-1:0]          high_code;
		logic [GAIN_W-1:0]          gain;
		logic signed [OFFSET_W-1:0] offset;
		reading_t                   expected_q[$];
		int unsigned                errors;

		function new();
			foreach (ring[i])
				ring[i] = '0;
			slot = 0;
			low_code = LOW_CODE_RST;
			high_code = HIGH_CODE_RST;
			gain = GAIN_RST;
			offset = OFFSET_RST;
			errors = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_LOW_CODE: low_code = d[CODE_W-1:0];
				REG_HIGH_CODE: high_code = d[HIGH_W-1:0];
				REG_GAIN: gain = d[GAIN_W-1:0];
				REG_OFFSET: offset = d[OFFSET_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_word(logic [RAW_W-1:0] w);
			logic [CODE_W-1:0] code;
			longint unsigned   sum;
			longint unsigned   scaled;
			int unsigned       cnt;
			longint            off64;
			longint            r;
			reading_t          exp_rd;
			code = w[RAW_W-1:CODE_LSB];
			exp_rd.accepted = (code > low_code) && (code < high_code);
			if (exp_rd.accepted) begin
				ring[slot] = code;
				slot = (slot + 1) % DEPTH_DEF;
			end
			sum = 0;
			cnt = 0;
			// empty slots are zero and stay out of the mean
			foreach (ring[i]) begin
				if (ring[i] != 0) begin
					sum += ring[i];
					cnt++;
				end
			end
			// unsigned product, truncating divide; empty ring divides by one
			scaled = (sum * gain) / longint'(cnt == 0 ? 1 : cnt);
			off64 = offset;
			r = longint'(scaled) + off64;
			if (r > READING_MAX)
				r = READING_MAX;
			if (r < READING_MIN)
				r = READING_MIN;
			exp_rd.reading = r[READING_W-1:0];
			exp_rd.count = cnt[COUNT_OUT_W-1:0];
			expected_q.push_back(exp_rd);
		endfunction

		function void check_reading(logic signed [READING_W-1:0] rd, logic acc,
				logic [COUNT_OUT_W-1:0] cnt);
			reading_t exp_rd;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%t: unexpected item: reading=%0d accepted=%0b count=%0d",
						$realtime, rd, acc, cnt);
				return;
			end
			exp_rd = expected_q.pop_front();
			if (rd !== exp_rd.reading || acc !== exp_rd.accepted || cnt !== exp_rd.count) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%t: mismatch: reading=%0d/%0d accepted=%0b/%0b count=%0d/%0d (got/exp)",
						$realtime, rd, exp_rd.reading, acc, exp_rd.accepted,
						cnt, exp_rd.count);
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic [RAW_W-1:0]            raw_word;
	logic                        out_valid;
	logic                        out_ready;
	logic signed [READING_W-1:0] reading;
	logic                        accepted;
	logic [COUNT_OUT_W-1:0]      valid_count;
	logic                        cfg_we;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [CFG_DATA_W-1:0]       cfg_data;

	reading_scoreboard sb = new();

	// set by the stimulus process; the receiver picks them up at its next edge
	int unsigned rx_hold_req = 0;
	bit          calm = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	gated_moving_average_scaler u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.raw_word   (raw_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.reading    (reading),
		.accepted   (accepted),
		.valid_count(valid_count),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Sender gap: mostly back to back, sometimes a few cycles, rarely long.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Most words carry a code inside the current window so the ring keeps
	// moving; the rest are anywhere, plus the odd zero code.
	function automatic logic [RAW_W-1:0] pick_word();
		logic [CODE_W-1:0] code;
		int unsigned       lo;
		int unsigned       hi;
		int unsigned       roll;
		lo = sb.low_code;
		hi = sb.high_code;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			code = '0;
		else if (roll < 16 && hi > lo + 1)
			code = CODE_W'($urandom_range(lo + 1, hi - 1));
		else
			code = CODE_W'($urandom_range(0, CODE_MAX));
		return {code, 4'($urandom_range(0, 15))};
	endfunction

	// Offers one word and holds it until taken. Valid stays high when no
	// gap follows, so back-to-back items never toggle it within a step.
	task automatic send_word(input logic [RAW_W-1:0] w);
		int unsigned gap;
		in_valid <= 1'b1;
		raw_word <= w;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_word(w);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering and waits for every predicted reading to come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes all four registers back to back; only called with the block idle.
	task automatic load_config(input logic [CFG_DATA_W-1:0] lo, hi, g, off);
		cfg_reg_t              order[4];
		logic [CFG_DATA_W-1:0] vals[4];
		order = '{REG_LOW_CODE, REG_HIGH_CODE, REG_GAIN, REG_OFFSET};
		vals = '{lo, hi, g, off};
		cfg_we <= 1'b1;
		for (int i = 0; i < 4; i++) begin
			cfg_index <= order[i];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.set_reg(order[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// Random setting, extremes weighted in: full or empty window, a window of
	// one code, zero and full gain, offset at both ends.
	task automatic random_config();
		int unsigned           lo;
		int unsigned           hi;
		logic [CFG_DATA_W-1:0] g;
		logic [CFG_DATA_W-1:0] off;
		case ($urandom_range(0, 5))
			0: lo = 0;
			1: lo = CODE_MAX;
			default: lo = $urandom_range(0, 3000);
		endcase
		case ($urandom_range(0, 9))
			0: hi = 4096;
			1: hi = $urandom_range(0, lo + 1);
			2: hi = lo + 2;
			default: hi = (lo + 2 > 4096) ? 4096 : $urandom_range(lo + 2, 4096);
		endcase
		case ($urandom_range(0, 4))
			0: g = '0;
			1: g = {GAIN_W{1'b1}};
			2: g = $urandom_range(0, 200000);
			default: g = $urandom_range(0, (1 << GAIN_W) - 1);
		endcase
		case ($urandom_range(0, 5))
			0: off = 32'h8000_0000;
			1: off = 32'h7FFF_FFFF;
			2: off = '0;
			default: off = $urandom;
		endcase
		load_config(lo, hi, g, off);
	endtask

	// Receiver: checks at each edge, then decides next ready. Short and long
	// stalls at random, none while calm, and a counted hold-off on request.
	initial begin : receiver
		int unsigned stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_reading(reading, accepted, valid_count);
			if (rx_hold_req > 0) begin
				stall_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 59) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(20, 70) - 1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(1, 3) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		in_valid <= 1'b0;
		raw_word <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_LOW_CODE;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty ring gives offset alone, a zero code and a code
		// equal to low_code are turned away, the top code gets in
		send_word(16'h0000);
		send_word(16'h400F);
		send_word(16'h4010);
		send_word(16'hFFFF);
		send_word(16'h0005);
		drain();

		// widest window, full gain, most negative then most positive offset
		load_config(32'd0, 32'd4096, {GAIN_W{1'b1}}, 32'h8000_0000);
		send_word(16'h0010);
		send_word(16'hFFF0);
		drain();
		load_config(32'd0, 32'd4096, {GAIN_W{1'b1}}, 32'h7FFF_FFFF);
		send_word(16'hFFFF);
		drain();

		// windows that no code can meet
		load_config(32'd2000, 32'd2001, 32'd81920, 32'd0);
		send_word(16'h7D00);
		send_word(16'h7D1F);
		drain();
		load_config(CODE_MAX, 32'd0, '0, '0);
		send_word(16'hFFFF);
		drain();

		// enough accepted codes to wrap the write slot past the ring end
		load_config(32'd0, 32'd4096, 32'h12_3456, 32'd0);
		for (int k = 0; k < 14; k++)
			send_word({12'(k * 291 + 1), 4'(k)});
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			random_config();
			calm = (p == 5 || p == 8);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// receiver holds off while words keep coming, so the
				// block fills and stalls its input
				if (p == 2 && k == 40)
					rx_hold_req = HOLD_CYCLES;
				// sender waits for every outstanding reading mid-phase
				if (p == 3 && k == 60)
					drain();
				send_word(pick_word());
			end
			drain();
		end
		calm = 1'b0;

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0d readings never arrived", sb.pending());
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("timeout with %0d readings outstanding", sb.pending());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/gmas_pkg.sv
sv/gmas_ring.sv
sv/gmas_div.sv
sv/gated_moving_average_scaler.sv
tb/sv/gated_moving_average_scaler_tb.sv
